### rtl/core/u8bmp_pkg.sv
// Shared types and constants for the UTF-8 BMP stream decoder.
package u8bmp_pkg;

    localparam logic [7:0] ASCII_LAST = 8'h7F;
    localparam logic [7:0] CONT_FIRST = 8'h80;
    localparam logic [7:0] CONT_LAST  = 8'hBF;
    localparam logic [7:0] LEAD2_LAST = 8'hDF;
    localparam logic [7:0] LEAD3_LAST = 8'hEF;
    localparam logic [7:0] LEAD4_LAST = 8'hF7;

    localparam logic [15:0] REPLACE_CHAR = 16'h003F;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    typedef logic [1:0] pend_t;
    typedef logic [9:0] partial_t;

    typedef struct packed {
        logic     emit;
        logic     [15:0] code_point;
        logic     has_char;
        logic     truncated;
        logic     end_of_string;
        pend_t    pending_next;
        partial_t partial_next;
    } dec_res_t;

endpackage

### rtl/core/u8bmp_decode.sv
// Decode step for one byte: result fields and next sequence state.
module u8bmp_decode
(
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  u8bmp_pkg::pend_t    pending,
    input  u8bmp_pkg::partial_t partial,
    output u8bmp_pkg::dec_res_t res
);

    logic        is_cont;
    logic [15:0] acc;

    assign is_cont = data_byte inside {[u8bmp_pkg::CONT_FIRST:u8bmp_pkg::CONT_LAST]};
    assign acc     = {partial, data_byte[5:0]};

    always_comb
    begin
        res               = '0;
        res.pending_next  = pending;
        res.partial_next  = partial;
        res.end_of_string = last_byte;

        if (pending != u8bmp_pkg::PEND_NONE && is_cont)
        begin
            res.pending_next = pending - 2'd1;
            if (pending == u8bmp_pkg::PEND_ONE)
            begin
                res.code_point   = acc;
                res.has_char     = 1'b1;
                res.partial_next = '0;
            end
            else
            begin
                res.partial_next = acc[9:0];
            end
        end
        else
        begin
            // drop any open sequence and decode the byte afresh
            res.pending_next = u8bmp_pkg::PEND_NONE;
            res.partial_next = '0;
            if (data_byte <= u8bmp_pkg::ASCII_LAST)
            begin
                res.code_point = {8'h00, data_byte};
                res.has_char   = 1'b1;
            end
            else if (is_cont)
            begin
                // stray continuation: ignore
            end
            else if (data_byte <= u8bmp_pkg::LEAD2_LAST)
            begin
                res.pending_next = u8bmp_pkg::PEND_ONE;
                res.partial_next = {5'b0, data_byte[4:0]};
            end
            else if (data_byte <= u8bmp_pkg::LEAD3_LAST)
            begin
                res.pending_next = u8bmp_pkg::PEND_TWO;
                res.partial_next = {6'b0, data_byte[3:0]};
            end
            else if (data_byte <= u8bmp_pkg::LEAD4_LAST)
            begin
                res.code_point = u8bmp_pkg::REPLACE_CHAR;
                res.has_char   = 1'b1;
            end
        end

        if (last_byte)
        begin
            res.truncated    = (res.pending_next != u8bmp_pkg::PEND_NONE);
            res.pending_next = u8bmp_pkg::PEND_NONE;
            res.partial_next = '0;
        end

        res.emit = res.has_char | last_byte;
    end

endmodule

### rtl/core/utf8_bmp_stream_decoder.sv
// Top level of the UTF-8 BMP stream decoder: input register, decode, result register.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid / in_ready | data_byte[7:0], last_byte
//  out     | out_valid/out_ready | code_point[15:0], has_char, truncated, end_of_string
//
// One byte per cycle sustained while no result is stalled.
// The rate is set by the single decode step between the input and result registers.
// Reset clears the sequence state and both stage valids.
// A stalled result holds; the input register still advances on bytes that give no result.
module utf8_bmp_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_point,
    output logic        has_char,
    output logic        truncated,
    output logic        end_of_string
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    u8bmp_pkg::pend_t    pending_reg;
    u8bmp_pkg::partial_t partial_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [15:0]         out_code_reg;
    logic                out_has_char_reg;
    logic                out_trunc_reg;
    logic                out_eos_reg;
    u8bmp_pkg::dec_res_t dec;
    logic                out_free;
    logic                step;

    u8bmp_decode u_decode
    (
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .pending   (pending_reg),
        .partial   (partial_reg),
        .res       (dec)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && (out_free || !dec.emit);
    assign in_ready = !in_valid_reg || step;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && dec.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= u8bmp_pkg::PEND_NONE;
            partial_reg   <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            // advance sequence state only when the byte leaves the input register
            if (step)
            begin
                pending_reg <= dec.pending_next;
                partial_reg <= dec.partial_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (step && dec.emit)
        begin
            out_code_reg     <= dec.code_point;
            out_has_char_reg <= dec.has_char;
            out_trunc_reg    <= dec.truncated;
            out_eos_reg      <= dec.end_of_string;
        end
    end

    assign out_valid     = out_valid_reg;
    assign code_point    = out_code_reg;
    assign has_char      = out_has_char_reg;
    assign truncated     = out_trunc_reg;
    assign end_of_string = out_eos_reg;

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("pending count out of range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_last_reg |=> pending_reg == u8bmp_pkg::PEND_NONE && partial_reg == '0)
        else $error("sequence state not cleared after final byte");

    a_result_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_has_char_reg || out_eos_reg)
        else $error("result with neither character nor end mark");

    a_trunc_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_trunc_reg |-> !out_has_char_reg && out_eos_reg)
        else $error("truncated result carries a character");

    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_has_char_reg |-> out_code_reg == 16'h0000)
        else $error("nonzero code point without a character");

endmodule
